### src/tste_pkg.sv
// ----------------------------------------------------------------------------
// tste_pkg
// Shared types and constants for the tour successor table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tste_pkg;

  // Field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned NODE_W = 10;
  localparam int unsigned VAL_W  = 11;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned ST_W   = 2;

  // Default table depth
  localparam int unsigned MaxNodesDefault = 1024;

  // Configuration port
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned DATA_W        = 32;
  localparam logic [0:0]  RegNodeCount  = 1'b0;
  localparam logic [CNT_W-1:0] NodeCountReset = 11'd1024;

  // Stored value meaning "no successor"
  localparam logic [VAL_W-1:0] NoneValue = '1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_REACH   = 3'd2,
    OP_REVERSE = 3'd3,
    OP_TOUR    = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNREACH  = 2'd1,
    ST_LIMIT    = 2'd2,
    ST_NONE_MET = 2'd3
  } status_e;

  // Configuration seen by the engine
  typedef struct packed {
    logic [CNT_W-1:0] node_count;
  } cfg_t;

endpackage

`default_nettype wire

### src/tste_if.sv
// ----------------------------------------------------------------------------
// tste_if
// Request and response channels of the tour successor table engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface tste_req_if;
  import tste_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [NODE_W-1:0]       node_a;
  logic [NODE_W-1:0]       node_b;
  logic signed [VAL_W-1:0] entry_value;

  modport source (output valid, operation, node_a, node_b, entry_value, input ready);
  modport sink   (input valid, operation, node_a, node_b, entry_value, output ready);
endinterface

interface tste_rsp_if;
  import tste_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic [CNT_W-1:0]        distance;
  logic signed [VAL_W-1:0] read_value;
  logic                    tour_ok;

  modport source (output valid, status, distance, read_value, tour_ok, input ready);
  modport sink   (input valid, status, distance, read_value, tour_ok, output ready);
endinterface

`default_nettype wire

### src/tste_apb_regs.sv
// ----------------------------------------------------------------------------
// tste_apb_regs
// APB-style register file holding the node count.
// ----------------------------------------------------------------------------
`default_nettype none

module tste_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tste_pkg::ADDR_W-1:0]  paddr,
  input  logic [tste_pkg::DATA_W-1:0]  pwdata,
  output logic [tste_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output tste_pkg::cfg_t               cfg_o
);
  import tste_pkg::*;

  logic [CNT_W-1:0] node_count_q;
  logic [CNT_W-1:0] node_count_d;
  logic             sel_count;

  // Register index is the word address
  assign sel_count = (paddr[ADDR_W-1] == RegNodeCount);
  assign pready    = 1'b1;

  // Write decode
  always_comb begin
    node_count_d = node_count_q;
    if (psel && penable && pwrite && sel_count) begin
      node_count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountReset;
    end else begin
      node_count_q <= node_count_d;
    end
  end

  // Read mux
  assign prdata = sel_count ? {{(DATA_W-CNT_W){1'b0}}, node_count_q} : '0;

  assign cfg_o.node_count = node_count_q;

endmodule

`default_nettype wire

### src/tour_successor_table_engine_core.sv
// ----------------------------------------------------------------------------
// tour_successor_table_engine_core
// Successor table with write, read, reach distance, path reversal and tour
// check, built around a successor RAM and a path stack RAM.
// ----------------------------------------------------------------------------
// One request at a time, one response each. Every table read goes through
// the single successor RAM read port (registered read), so the walks set
// the pace: a reach distance or tour check reads one entry per step, and a
// reversal along a path of k nodes takes k - 1 walk reads, then k - 1 table
// writes fed by the path stack RAM, bounded by the node count.
// A request is taken whenever the engine is idle, even while the previous
// response still waits in the output register. Both RAMs start undefined
// and need no clearing pass; a walk through an entry that was never written
// gives an undefined answer.
// ----------------------------------------------------------------------------
`default_nettype none

module tour_successor_table_engine_core #(
  parameter int unsigned MAX_NODES = tste_pkg::MaxNodesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tste_req_if.sink                     req_i,
  tste_rsp_if.source                   rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tste_pkg::ADDR_W-1:0]  paddr,
  input  logic [tste_pkg::DATA_W-1:0]  pwdata,
  output logic [tste_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import tste_pkg::*;

  localparam int unsigned AW = $clog2(MAX_NODES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_REV_WR,
    S_FINISH
  } state_e;

  // Helpers
  function automatic logic in_tbl(logic [NODE_W-1:0] nd);
    return (32'(nd) < MAX_NODES);
  endfunction

  function automatic logic [AW-1:0] node_addr(logic [NODE_W-1:0] nd);
    logic [31:0] w;
    w = 32'(nd);
    return w[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] cnt_addr(logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[AW-1:0];
  endfunction

  // Configuration
  cfg_t             cfg;
  logic [CNT_W-1:0] n_eff;

  tste_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Walk bound: node count capped at the table depth
  assign n_eff = (32'(cfg.node_count) > MAX_NODES) ? CNT_W'(MAX_NODES) : cfg.node_count;

  // Memories
  logic [VAL_W-1:0]  tbl_mem [MAX_NODES];
  logic [VAL_W-1:0]  tbl_rdata_q;
  logic              tbl_we, tbl_re;
  logic [AW-1:0]     tbl_waddr, tbl_raddr;
  logic [VAL_W-1:0]  tbl_wdata;

  logic [NODE_W-1:0] stk_mem [MAX_NODES];
  logic [NODE_W-1:0] stk_rdata_q;
  logic              stk_we, stk_re;
  logic [AW-1:0]     stk_waddr, stk_raddr;
  logic [NODE_W-1:0] stk_wdata;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rdata_q <= tbl_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  // Engine registers
  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [NODE_W-1:0] a_q, a_d;
  logic [NODE_W-1:0] b_q, b_d;
  logic [NODE_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0]  steps_q, steps_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic              first_q, first_d;
  logic              oob_q, oob_d;
  logic [ST_W-1:0]   res_status_q, res_status_d;
  logic [CNT_W-1:0]  res_dist_q, res_dist_d;
  logic [VAL_W-1:0]  res_read_q, res_read_d;
  logic              res_tour_q, res_tour_d;
  logic              out_valid_q, out_valid_d;
  logic [ST_W-1:0]   out_status_q, out_status_d;
  logic [CNT_W-1:0]  out_dist_q, out_dist_d;
  logic [VAL_W-1:0]  out_read_q, out_read_d;
  logic              out_tour_q, out_tour_d;

  logic              accept;
  logic [VAL_W-1:0]  v;
  logic [NODE_W-1:0] vnode;
  logic              v_valid;
  logic [NODE_W-1:0] cmp_node;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Entry under inspection; a node outside the table reads as none
  assign v        = oob_q ? NoneValue : tbl_rdata_q;
  assign vnode    = v[NODE_W-1:0];
  assign v_valid  = !v[VAL_W-1] && in_tbl(vnode);
  assign cmp_node = (op_q == OP_REACH) ? a_q : '0;

  // Next-state and memory control
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    a_d          = a_q;
    b_d          = b_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    j_d          = j_q;
    first_d      = first_q;
    oob_d        = oob_q;
    res_status_d = res_status_q;
    res_dist_d   = res_dist_q;
    res_read_d   = res_read_q;
    res_tour_d   = res_tour_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_dist_d   = out_dist_q;
    out_read_d   = out_read_q;
    out_tour_d   = out_tour_q;

    tbl_we    = 1'b0;
    tbl_waddr = node_addr(cur_q);
    tbl_wdata = {1'b0, stk_rdata_q};
    tbl_re    = 1'b0;
    tbl_raddr = node_addr(vnode);
    stk_we    = 1'b0;
    stk_waddr = cnt_addr(steps_q);
    stk_wdata = vnode;
    stk_re    = 1'b0;
    stk_raddr = cnt_addr(steps_q - CNT_W'(1));

    unique case (state_q)
      // Take a request and issue its first access
      S_IDLE: begin
        if (accept) begin
          op_d         = req_i.operation;
          a_d          = req_i.node_a;
          b_d          = req_i.node_b;
          cur_d        = req_i.node_a;
          steps_d      = '0;
          first_d      = 1'b1;
          oob_d        = !in_tbl(req_i.node_a);
          res_status_d = ST_OK;
          res_dist_d   = '0;
          res_read_d   = '0;
          res_tour_d   = 1'b0;
          tbl_raddr    = node_addr(req_i.node_a);
          unique case (req_i.operation)
            OP_WRITE: begin
              tbl_we    = in_tbl(req_i.node_a);
              tbl_waddr = node_addr(req_i.node_a);
              tbl_wdata = req_i.entry_value;
              state_d   = S_FINISH;
            end
            OP_READ, OP_REACH: begin
              tbl_re  = 1'b1;
              state_d = S_WALK;
            end
            OP_TOUR: begin
              tbl_re    = 1'b1;
              tbl_raddr = '0;
              oob_d     = 1'b0;
              state_d   = S_WALK;
            end
            OP_REVERSE: begin
              if (req_i.node_a == req_i.node_b) begin
                state_d = S_FINISH;
              end else begin
                tbl_re    = 1'b1;
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = req_i.node_a;
                steps_d   = CNT_W'(1);
                state_d   = S_WALK;
              end
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end

      // One successor entry per cycle
      S_WALK: begin
        unique case (op_q)
          OP_READ: begin
            res_read_d = v;
            state_d    = S_FINISH;
          end
          OP_REVERSE: begin
            if (!v_valid) begin
              res_status_d = ST_NONE_MET;
              state_d      = S_FINISH;
            end else if (steps_q >= n_eff) begin
              res_status_d = ST_LIMIT;
              state_d      = S_FINISH;
            end else begin
              // push the successor, stop once the path end is reached
              stk_we  = 1'b1;
              steps_d = steps_q + CNT_W'(1);
              cur_d   = vnode;
              if (vnode == b_q) begin
                stk_re  = 1'b1;
                j_d     = steps_q - CNT_W'(1);
                state_d = S_REV_WR;
              end else begin
                tbl_re = 1'b1;
                oob_d  = 1'b0;
              end
            end
          end
          default: begin
            // reach distance and tour check share the walk
            if (!first_q && (v == {1'b0, cmp_node})) begin
              if (op_q == OP_REACH) begin
                res_status_d = ST_UNREACH;
              end else begin
                res_status_d = ST_OK;
                res_tour_d   = ({1'b0, steps_q} + 12'd1) == {1'b0, cfg.node_count};
              end
              state_d = S_FINISH;
            end else if (steps_q >= n_eff) begin
              res_status_d = ST_LIMIT;
              state_d      = S_FINISH;
            end else if (!v_valid) begin
              res_status_d = ST_UNREACH;
              state_d      = S_FINISH;
            end else begin
              steps_d = steps_q + CNT_W'(1);
              first_d = 1'b0;
              oob_d   = 1'b0;
              if ((op_q == OP_REACH) && (vnode == b_q)) begin
                res_status_d = ST_OK;
                res_dist_d   = steps_q + CNT_W'(1);
                state_d      = S_FINISH;
              end else begin
                tbl_re = 1'b1;
              end
            end
          end
        endcase
      end

      // Point each path node back at its predecessor
      S_REV_WR: begin
        tbl_we = 1'b1;
        cur_d  = stk_rdata_q;
        if (j_q == '0) begin
          res_status_d = ST_OK;
          state_d      = S_FINISH;
        end else begin
          stk_re    = 1'b1;
          stk_raddr = cnt_addr(j_q - CNT_W'(1));
          j_d       = j_q - CNT_W'(1);
        end
      end

      // Hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_dist_d   = res_dist_q;
          out_read_d   = res_read_q;
          out_tour_d   = res_tour_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    a_q          <= a_d;
    b_q          <= b_d;
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    j_q          <= j_d;
    first_q      <= first_d;
    oob_q        <= oob_d;
    res_status_q <= res_status_d;
    res_dist_q   <= res_dist_d;
    res_read_q   <= res_read_d;
    res_tour_q   <= res_tour_d;
    out_status_q <= out_status_d;
    out_dist_q   <= out_dist_d;
    out_read_q   <= out_read_d;
    out_tour_q   <= out_tour_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.distance   = out_dist_q;
  assign rsp_o.read_value = out_read_q;
  assign rsp_o.tour_ok    = out_tour_q;

`ifndef NO_ASSERTIONS
  // Walks only read the table
  a_walk_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> !tbl_we)
    else $error("table written during a walk");

  // A response appears only out of the finish state
  a_rsp_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("response loaded outside finish");

  // Rewrite index stays below the path length
  a_rev_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REV_WR) |-> (j_q < steps_q))
    else $error("reversal index beyond path");

  // Finish leads only back to idle
  a_finish_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |=> (state_q == S_FINISH || state_q == S_IDLE))
    else $error("bad exit from finish");
`endif

endmodule

`default_nettype wire

### tb/tour_successor_table_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tour_successor_table_engine_core_tb
// Self-checking bench for the successor table engine: a directed pass over
// writes, reads, walks, reversals and node-count extremes, then random phases
// that each lay down a fresh tour and hit it with mixed requests. A scoreboard
// class predicts every response and checks them in order.
// ----------------------------------------------------------------------------

import tste_pkg::*;

typedef struct packed {
  logic [OP_W-1:0]         op;
  logic [NODE_W-1:0]       node_a;
  logic [NODE_W-1:0]       node_b;
  logic signed [VAL_W-1:0] entry_value;
} tour_req_t;

typedef struct packed {
  status_e                 status;
  logic [CNT_W-1:0]        distance;
  logic signed [VAL_W-1:0] read_value;
  logic                    tour_ok;
} tour_rsp_t;

// Mirror of the successor table plus the queue of pending responses
class successor_scoreboard;
  logic signed [VAL_W-1:0] succ_tbl [MaxNodesDefault];
  bit                      written  [MaxNodesDefault];
  int                      path_buf [MaxNodesDefault];
  logic [CNT_W-1:0]        node_count;
  tour_rsp_t               expected_q [$];
  int                      mismatches;
  bit                      undef_seen;

  function new();
    node_count = NodeCountReset;
    mismatches = 0;
  endfunction

  function void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // Entry lookup; flags any touch of a never-written entry
  function int entry(int node);
    if (!written[node]) undef_seen = 1'b1;
    return int'(succ_tbl[node]);
  endfunction

  // Successor for walking, -1 when none
  function int next_node(int node);
    int v;
    v = entry(node);
    return (v < 0) ? -1 : v;
  endfunction

  function tour_rsp_t predict(tour_req_t r, bit commit);
    tour_rsp_t rsp;
    int n, a, b, cur, steps, nx, k;
    rsp = '0;
    undef_seen = 1'b0;
    a = r.node_a;
    b = r.node_b;
    n = (node_count > MaxNodesDefault) ? MaxNodesDefault : node_count;
    case (r.op)
      OP_WRITE: begin
        if (commit) begin
          succ_tbl[a] = r.entry_value;
          written[a]  = 1'b1;
        end
      end
      OP_READ: begin
        void'(entry(a));
        rsp.read_value = succ_tbl[a];
      end
      OP_REACH: begin
        rsp.status = ST_LIMIT;
        cur = a;
        steps = 0;
        while (steps < n) begin
          nx = next_node(cur);
          if (nx < 0) begin
            rsp.status = ST_UNREACH;
            break;
          end
          cur = nx;
          steps++;
          if (cur == b) begin
            rsp.status   = ST_OK;
            rsp.distance = CNT_W'(steps);
            break;
          end
          // back at the start node: b is not on this cycle
          if (entry(cur) == a) begin
            rsp.status = ST_UNREACH;
            break;
          end
        end
      end
      OP_REVERSE: begin
        path_buf[0] = a;
        k = 1;
        while (path_buf[k-1] != b) begin
          nx = next_node(path_buf[k-1]);
          if (nx < 0) begin
            rsp.status = ST_NONE_MET;
            break;
          end
          if (k >= n) begin
            rsp.status = ST_LIMIT;
            break;
          end
          path_buf[k] = nx;
          k++;
        end
        // table only changes on a clean walk
        if (commit && rsp.status == ST_OK) begin
          for (int i = k - 1; i >= 1; i--) begin
            succ_tbl[path_buf[i]] = VAL_W'(path_buf[i-1]);
            written[path_buf[i]]  = 1'b1;
          end
        end
      end
      OP_TOUR: begin
        rsp.status = ST_LIMIT;
        cur = 0;
        steps = 0;
        while (steps < n) begin
          nx = next_node(cur);
          if (nx < 0) begin
            rsp.status = ST_UNREACH;
            break;
          end
          cur = nx;
          steps++;
          if (entry(cur) == 0) begin
            rsp.status  = ST_OK;
            rsp.tour_ok = (steps + 1 == node_count);
            break;
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // True when the request stays on written entries
  function bit is_safe(tour_req_t r);
    void'(predict(r, 1'b0));
    return !undef_seen;
  endfunction

  function void note_request(tour_req_t r);
    expected_q.push_back(predict(r, 1'b1));
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction

  function void check_response(tour_rsp_t got);
    tour_rsp_t want;
    if (expected_q.size() == 0) begin
      log_mismatch($sformatf("response with nothing pending (status %0d)", got.status));
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status)
      log_mismatch($sformatf("status: expected %0d, got %0d", want.status, got.status));
    if (got.distance !== want.distance)
      log_mismatch($sformatf("distance: expected %0d, got %0d", want.distance, got.distance));
    if (got.read_value !== want.read_value)
      log_mismatch($sformatf("read_value: expected %0d, got %0d",
                             $signed(want.read_value), $signed(got.read_value)));
    if (got.tour_ok !== want.tour_ok)
      log_mismatch($sformatf("tour_ok: expected %0b, got %0b", want.tour_ok, got.tour_ok));
  endfunction
endclass

module tour_successor_table_engine_core_tb;

  localparam int unsigned ITEM_TARGET  = 290;
  localparam int unsigned QUIET_TAIL   = 50;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam logic [OP_W-1:0]   OP_LAST        = '1;
  localparam logic [ADDR_W-1:0] NODE_COUNT_ADDR = ADDR_W'({RegNodeCount, 2'b00});

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tste_req_if req_if ();
  tste_rsp_if rsp_if ();

  successor_scoreboard sb = new();

  bit        quiet    = 1'b0;
  bit        hold_rsp = 1'b0;
  int        items_sent = 0;
  int        cycle_count = 0;
  tour_rsp_t seen_rsp;

  tour_successor_table_engine_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if.sink),
    .rsp_o   (rsp_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Response monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      seen_rsp.status     = status_e'(rsp_if.status);
      seen_rsp.distance   = rsp_if.distance;
      seen_rsp.read_value = rsp_if.read_value;
      seen_rsp.tour_ok    = rsp_if.tour_ok;
      sb.check_response(seen_rsp);
    end
  end

  // Response side: random stalls, plus one long hold-off on request
  initial begin : response_sink
    int k;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready = 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk_i);
        hold_rsp = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
    end
  end

  // Offer one request, starting and ending at a falling edge
  task automatic drive_request(input tour_req_t r);
    // no idling once the run reaches its last stretch
    quiet = (items_sent >= ITEM_TARGET - QUIET_TAIL);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    req_if.valid       = 1'b1;
    req_if.operation   = r.op;
    req_if.node_a      = r.node_a;
    req_if.node_b      = r.node_b;
    req_if.entry_value = r.entry_value;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic directed(input logic [OP_W-1:0] op, input int a, input int b, input int v);
    tour_req_t r;
    r.op          = op;
    r.node_a      = NODE_W'(a);
    r.node_b      = NODE_W'(b);
    r.entry_value = VAL_W'(v);
    drive_request(r);
  endtask

  // Program node_count once the engine is idle, then read it back
  task automatic write_node_count(input logic [CNT_W-1:0] value);
    logic [DATA_W-1:0] got;
    req_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = NODE_COUNT_ADDR;
    pwdata  = DATA_W'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    sb.node_count = value;
    if (got !== DATA_W'(value))
      sb.log_mismatch($sformatf("node_count readback: expected %0d, got %0d", value, got));
  endtask

  // Mostly nodes of the current tour, sometimes anywhere in the table
  function automatic int ring_node(input int ring[$]);
    if ($urandom_range(0, 99) < 85) return ring[$urandom_range(0, ring.size() - 1)];
    return $urandom_range(0, MaxNodesDefault - 1);
  endfunction

  function automatic tour_req_t random_request(input int ring[$]);
    tour_req_t r;
    int pick, sel;
    for (int tries = 0; tries < 40; tries++) begin
      pick          = $urandom_range(0, 99);
      r.node_a      = NODE_W'(ring_node(ring));
      r.node_b      = NODE_W'(ring_node(ring));
      r.entry_value = VAL_W'($urandom_range(0, 2047));
      if (pick < 12) begin
        r.op = OP_WRITE;
        sel  = $urandom_range(0, 99);
        if (sel < 60)      r.entry_value = VAL_W'(ring[$urandom_range(0, ring.size() - 1)]);
        else if (sel < 80) r.entry_value = VAL_W'($urandom_range(0, MaxNodesDefault - 1));
        else if (sel < 90) r.entry_value = NoneValue;
        else               r.entry_value = VAL_W'(11'h400 | $urandom_range(0, 1023));
      end else if (pick < 27) begin
        r.op = OP_READ;
      end else if (pick < 57) begin
        r.op = OP_REACH;
      end else if (pick < 82) begin
        r.op = OP_REVERSE;
      end else if (pick < 95) begin
        r.op = OP_TOUR;
      end else begin
        r.op = OP_W'($urandom_range(int'(OP_TOUR) + 1, int'(OP_LAST)));
      end
      if (sb.is_safe(r)) return r;
    end
    r        = '0;
    r.op     = OP_READ;
    r.node_a = NODE_W'(ring[0]);
    return r;
  endfunction

  // One phase: set node_count, lay down a fresh tour through node 0, mix requests
  task automatic random_phase(input bit with_hold);
    int               size, sel, node, start, ops;
    logic [CNT_W-1:0] count;
    int               ring [$];
    bit               taken [MaxNodesDefault];
    tour_req_t        r;
    size = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(3, 16);
    sel  = $urandom_range(0, 19);
    if (sel < 12)      count = CNT_W'(size);
    else if (sel < 15) count = CNT_W'(size + $urandom_range(1, 3));
    else if (sel < 18) count = CNT_W'($urandom_range(2, size - 1));
    else               count = NodeCountReset;
    write_node_count(count);
    if (with_hold) hold_rsp = 1'b1;

    ring.push_back(0);
    taken[0] = 1'b1;
    while (ring.size() < size) begin
      node = $urandom_range(1, MaxNodesDefault - 1);
      if (!taken[node]) begin
        taken[node] = 1'b1;
        ring.push_back(node);
      end
    end

    // write the ring links from a random starting point
    start = $urandom_range(0, size - 1);
    for (int i = 0; i < size; i++) begin
      r             = '0;
      r.op          = OP_WRITE;
      r.node_a      = NODE_W'(ring[(start + i) % size]);
      r.entry_value = VAL_W'(ring[(start + i + 1) % size]);
      drive_request(r);
    end

    // check the fresh tour first most of the time
    if ($urandom_range(0, 2) != 0) directed(OP_TOUR, 0, 0, 0);
    ops = $urandom_range(12, 28);
    repeat (ops) drive_request(random_request(ring));
  endtask

  initial begin : stimulus
    int phase;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.operation   = '0;
    req_if.node_a      = '0;
    req_if.node_b      = '0;
    req_if.entry_value = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Four-node ring 0 -> 5 -> 1023 -> 512 -> 0, plus none entries
    directed(OP_WRITE, 0, 0, 5);
    directed(OP_WRITE, 5, 0, 1023);
    directed(OP_WRITE, 1023, 1023, 512);
    directed(OP_WRITE, 512, 0, 0);
    directed(OP_WRITE, 700, 0, -1);
    directed(OP_WRITE, 701, 0, -1024);
    directed(OP_READ, 1023, 0, 0);
    directed(OP_READ, 701, 1023, -1);
    directed(OP_READ, 700, 0, 0);
    // reach: found, back at start, none entry, negative entry
    directed(OP_REACH, 0, 512, 0);
    directed(OP_REACH, 0, 700, 0);
    directed(OP_REACH, 700, 0, 0);
    directed(OP_REACH, 701, 5, 0);
    directed(OP_TOUR, 0, 0, 0);
    // reversal: clean, a equal to b, none entry, endless loop
    directed(OP_REVERSE, 0, 1023, 0);
    directed(OP_REVERSE, 5, 5, 0);
    directed(OP_REVERSE, 700, 0, 0);
    directed(OP_REVERSE, 0, 700, 0);
    directed(OP_W'(OP_TOUR + 1), 1023, 1023, -1);
    directed(OP_LAST, 0, 0, 0);

    // Zero count: every walk hits the limit at once
    write_node_count('0);
    directed(OP_TOUR, 0, 0, 0);
    directed(OP_REACH, 0, 5, 0);
    directed(OP_REVERSE, 5, 5, 0);
    directed(OP_REVERSE, 0, 5, 0);
    // Smallest legal count closes the 0 <-> 5 loop
    write_node_count(CNT_W'(2));
    directed(OP_TOUR, 0, 0, 0);
    // Count above the table depth is capped
    write_node_count('1);
    directed(OP_TOUR, 0, 0, 0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      random_phase(phase == 1);
      phase++;
    end

    req_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
